[hw/rtl/rrel_pkg.sv]
// shared types and constants for the round-robin entry list unit
// no dependencies
package rrel_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_NEXT   = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH,
      S_SHIFT,
      S_NEXT_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      func_type               func;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] out_value;
      status_type             status;
      logic [4:0]             entry_count;
   } rsp_type;

endpackage

[hw/rtl/rrel_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module rrel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/round_robin_entry_list_unit.sv]
// round-robin entry list: add, remove with compaction, and get next; depends on rrel_pkg, rrel_ram
// order: add, no-op, and remove or next on an empty list go straight from dispatch to the response state;
// next reads the ram in a wait state first; remove searches then shifts, one entry a cycle
// through the single ram read port; any response stall holds the response state
// one request at a time; the next request can be taken in the same cycle that the response is raised
// synchronous active-high reset empties the list and clears the position
module round_robin_entry_list_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrel_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrel_pkg::rsp_type rsp_data
);

   rrel_pkg::state_type             state_ff, state_in;
   rrel_pkg::req_type               op_ff, op_in;
   logic [rrel_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [rrel_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic [rrel_pkg::IDX_W-1:0]      idx_ff, idx_in;
   rrel_pkg::status_type            status_ff, status_in;
   logic [rrel_pkg::VALUE_WIDTH-1:0] outv_ff, outv_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rrel_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            ram_we;
   logic [rrel_pkg::IDX_W-1:0]      ram_waddr;
   logic [rrel_pkg::VALUE_WIDTH-1:0] ram_wdata;
   logic [rrel_pkg::IDX_W-1:0]      ram_raddr;
   logic [rrel_pkg::VALUE_WIDTH-1:0] ram_rdata;

   logic                            req_take;
   logic                            hit;
   logic                            search_more;
   logic                            shift_more;
   logic                            rsp_free;
   logic [rrel_pkg::CNT_W-1:0]      count_dec;
   logic [rrel_pkg::IDX_W-1:0]      pos_adj;

   rrel_ram #(
      .WIDTH(rrel_pkg::VALUE_WIDTH),
      .DEPTH(rrel_pkg::CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_stall   = (state_ff != rrel_pkg::S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign hit         = (ram_rdata == op_ff.value);
   assign search_more = ((rrel_pkg::CNT_W'(idx_ff) + rrel_pkg::CNT_W'(1)) < count_ff);
   assign shift_more  = ((rrel_pkg::CNT_W'(idx_ff) + rrel_pkg::CNT_W'(2)) < count_ff);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign count_dec   = count_ff - rrel_pkg::CNT_W'(1);
   assign pos_adj     = (pos_ff > idx_ff) ? (pos_ff - rrel_pkg::IDX_W'(1)) : pos_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrel_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = rrel_pkg::S_DISPATCH;
            end
         end
         rrel_pkg::S_DISPATCH: begin
            state_in = rrel_pkg::S_DONE;
            if (op_ff.func == rrel_pkg::FUNC_REMOVE && count_ff != '0) begin
               state_in = rrel_pkg::S_SEARCH;
            end else if (op_ff.func == rrel_pkg::FUNC_NEXT && count_ff != '0) begin
               state_in = rrel_pkg::S_NEXT_WAIT;
            end
         end
         rrel_pkg::S_SEARCH: begin
            if (hit) begin
               state_in = search_more ? rrel_pkg::S_SHIFT : rrel_pkg::S_DONE;
            end else if (!search_more) begin
               state_in = rrel_pkg::S_DONE;
            end
         end
         rrel_pkg::S_SHIFT: begin
            if (!shift_more) begin
               state_in = rrel_pkg::S_DONE;
            end
         end
         rrel_pkg::S_NEXT_WAIT: begin
            state_in = rrel_pkg::S_DONE;
         end
         rrel_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = rrel_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rrel_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in        = op_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      outv_in      = outv_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[rrel_pkg::IDX_W-1:0];
      ram_wdata    = op_ff.value;
      ram_raddr    = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         rrel_pkg::S_IDLE: begin
            if (req_take) begin
               op_in     = req_data;
               status_in = rrel_pkg::ST_OK;
               outv_in   = '0;
            end
         end
         rrel_pkg::S_DISPATCH: begin
            case (op_ff.func)
               rrel_pkg::FUNC_ADD: begin
                  if (count_ff == rrel_pkg::CNT_W'(rrel_pkg::CAPACITY)) begin
                     status_in = rrel_pkg::ST_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + rrel_pkg::CNT_W'(1);
                  end
               end
               rrel_pkg::FUNC_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = rrel_pkg::ST_NOT_FOUND;
                  end else begin
                     ram_raddr = '0;
                     idx_in    = '0;
                  end
               end
               rrel_pkg::FUNC_NEXT: begin
                  if (count_ff == '0) begin
                     status_in = rrel_pkg::ST_EMPTY;
                  end else begin
                     ram_raddr = pos_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         rrel_pkg::S_SEARCH: begin
            if (hit) begin
               if (search_more) begin
                  pos_in    = pos_adj;
                  ram_raddr = idx_ff + rrel_pkg::IDX_W'(1);
               end else begin
                  count_in = count_dec;
                  pos_in   = (rrel_pkg::CNT_W'(pos_adj) >= count_dec) ? '0 : pos_adj;
               end
            end else if (search_more) begin
               ram_raddr = idx_ff + rrel_pkg::IDX_W'(1);
               idx_in    = idx_ff + rrel_pkg::IDX_W'(1);
            end else begin
               status_in = rrel_pkg::ST_NOT_FOUND;
            end
         end
         rrel_pkg::S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (shift_more) begin
               ram_raddr = idx_ff + rrel_pkg::IDX_W'(2);
               idx_in    = idx_ff + rrel_pkg::IDX_W'(1);
            end else begin
               count_in = count_dec;
               pos_in   = (rrel_pkg::CNT_W'(pos_ff) >= count_dec) ? '0 : pos_ff;
            end
         end
         rrel_pkg::S_NEXT_WAIT: begin
            outv_in = ram_rdata;
            if ((rrel_pkg::CNT_W'(pos_ff) + rrel_pkg::CNT_W'(1)) >= count_ff) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + rrel_pkg::IDX_W'(1);
            end
         end
         rrel_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_value   = outv_ff;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = 5'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrel_pkg::S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      outv_ff   <= outv_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[tb/sv/round_robin_entry_list_unit_tb.sv]
// testbench for round_robin_entry_list_unit: a directed table, then random traffic of add, remove,
// next and no-op; responses are checked against the table or an in-bench list model, with random
// request idle gaps and response stalls; depends on rrel_pkg and the round_robin_entry_list_unit rtl
`timescale 1ns / 100ps

module round_robin_entry_list_unit_tb;
   import rrel_pkg::*;

   localparam int NUM_RANDOM  = 1000;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 2 * CAPACITY + 10;

   typedef struct packed {
      func_type               func;
      logic [VALUE_WIDTH-1:0] value;
      logic                   typed;
      logic [VALUE_WIDTH-1:0] e_value;
      status_type             e_status;
      logic [4:0]             e_count;
   } list_step_type;

   localparam int NUM_DIRECTED = 28;
   localparam list_step_type LIST_STEPS [NUM_DIRECTED] = '{
      '{FUNC_NEXT,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY,     5'd0},
      '{FUNC_REMOVE, 32'h0000_0005, 1'b1, 32'h0, ST_NOT_FOUND, 5'd0},
      '{FUNC_NOP,    32'hffff_ffff, 1'b1, 32'h0, ST_OK,        5'd0},
      '{FUNC_ADD,    32'h0000_0000, 1'b1, 32'h0, ST_OK,        5'd1},
      '{FUNC_ADD,    32'hffff_ffff, 1'b1, 32'h0, ST_OK,        5'd2},
      '{FUNC_ADD,    32'h0000_0001, 1'b1, 32'h0, ST_OK,        5'd3},
      '{FUNC_ADD,    32'h8000_0000, 1'b1, 32'h0, ST_OK,        5'd4},
      '{FUNC_ADD,    32'h0000_0007, 1'b1, 32'h0, ST_OK,        5'd5},
      '{FUNC_ADD,    32'ha5a5_a5a5, 1'b1, 32'h0, ST_OK,        5'd6},
      '{FUNC_ADD,    32'h5a5a_5a5a, 1'b1, 32'h0, ST_OK,        5'd7},
      '{FUNC_ADD,    32'h0000_0007, 1'b1, 32'h0, ST_OK,        5'd8},
      '{FUNC_ADD,    32'hffff_fffe, 1'b1, 32'h0, ST_OK,        5'd9},
      '{FUNC_ADD,    32'h7fff_ffff, 1'b1, 32'h0, ST_OK,        5'd10},
      '{FUNC_ADD,    32'h0000_ffff, 1'b1, 32'h0, ST_OK,        5'd11},
      '{FUNC_ADD,    32'hffff_0000, 1'b1, 32'h0, ST_OK,        5'd12},
      '{FUNC_ADD,    32'h0000_0002, 1'b1, 32'h0, ST_OK,        5'd13},
      '{FUNC_ADD,    32'h0000_0003, 1'b1, 32'h0, ST_OK,        5'd14},
      '{FUNC_ADD,    32'h1357_9bdf, 1'b1, 32'h0, ST_OK,        5'd15},
      '{FUNC_ADD,    32'h2468_ace0, 1'b1, 32'h0, ST_OK,        5'd16},
      '{FUNC_ADD,    32'hffff_ffff, 1'b1, 32'h0, ST_FULL,      5'd16},
      '{FUNC_NEXT,   32'hffff_ffff, 1'b1, 32'h0, ST_OK,        5'd16},
      '{FUNC_NEXT,   32'h0000_0000, 1'b1, 32'hffff_ffff, ST_OK, 5'd16},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0, ST_OK,        5'd0},
      '{FUNC_REMOVE, 32'h1234_5678, 1'b1, 32'h0, ST_NOT_FOUND, 5'd15},
      '{FUNC_NEXT,   32'h0000_0000, 1'b0, 32'h0, ST_OK,        5'd0},
      '{FUNC_REMOVE, 32'h8000_0000, 1'b0, 32'h0, ST_OK,        5'd0},
      '{FUNC_REMOVE, 32'h0000_0007, 1'b0, 32'h0, ST_OK,        5'd0},
      '{FUNC_NEXT,   32'h0000_0000, 1'b0, 32'h0, ST_OK,        5'd0}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [VALUE_WIDTH-1:0] list_vals [CAPACITY];
   int                     list_count = 0;
   int                     list_pos   = 0;

   rsp_type pending_list_rsps [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   int      stall_left  = 0;
   logic    quiet       = 1'b0;

   round_robin_entry_list_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rsp_type predict_list_op(input req_type r);
      rsp_type res;
      int      i;
      int      hit;
      res = '0;
      res.status = ST_OK;
      case (r.func)
         FUNC_ADD: begin
            if (list_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_vals[list_count] = r.value;
               list_count++;
               if (list_count == 1) list_pos = 0;
            end
         end
         FUNC_REMOVE: begin
            hit = -1;
            for (i = 0; i < list_count; i++) begin
               if (hit < 0 && list_vals[i] == r.value) hit = i;
            end
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               if (list_pos > hit) list_pos--;
               for (i = hit; i + 1 < list_count; i++) list_vals[i] = list_vals[i + 1];
               list_count--;
               if (list_pos >= list_count) list_pos = 0;
            end
         end
         FUNC_NEXT: begin
            if (list_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (list_pos >= list_count) list_pos = 0;
               res.out_value = list_vals[list_pos];
               list_pos++;
               if (list_pos >= list_count) list_pos = 0;
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(list_count);
      return res;
   endfunction

   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic func_type pick_func(input int mode);
      int roll;
      int add_pct;
      roll = $urandom_range(0, 99);
      add_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 50;
      if (roll < 3) return FUNC_NOP;
      if (roll < 28) return FUNC_NEXT;
      if ($urandom_range(0, 99) < add_pct) return FUNC_ADD;
      return FUNC_REMOVE;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value(input func_type f);
      if (f == FUNC_REMOVE && list_count > 0 && $urandom_range(0, 3) != 0)
         return list_vals[$urandom_range(0, list_count - 1)];
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   task automatic issue_request(input req_type r, input rsp_type want);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_list_rsps.insert(pending_list_rsps.size(), want);
   endtask

   task automatic idle_gap();
      int n;
      n = quiet ? 0 : pick_idle();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_list_rsps();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_list_rsps.size() != 0);
   endtask

   task automatic check_list_rsp(input rsp_type got);
      rsp_type want;
      if (pending_list_rsps.size() == 0) begin
         $error("unexpected response: out_value %h status %0d entry_count %0d",
                got.out_value, got.status, got.entry_count);
         fail_count++;
      end else begin
         want = pending_list_rsps.pop_front();
         if (got.out_value !== want.out_value) begin
            $error("out_value: expected %h, actual %h", want.out_value, got.out_value);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_list_rsp(rsp_data);
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
         stall_left = pick_idle();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_type       r;
      rsp_type       want;
      list_step_type row;
      int            mode;
      mode = 2;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = LIST_STEPS[i];
         r.func  = row.func;
         r.value = row.value;
         want = predict_list_op(r);
         if (row.typed) begin
            want.out_value   = row.e_value;
            want.status      = row.e_status;
            want.entry_count = row.e_count;
         end
         issue_request(r, want);
         idle_gap();
      end
      drain_list_rsps();

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 50 == 0) mode = $urandom_range(0, 2);
         quiet   <= (n % 300) < 40;
         r.func  = pick_func(mode);
         r.value = pick_value(r.func);
         want = predict_list_op(r);
         issue_request(r, want);
         if (n % 200 == 199) drain_list_rsps();
         else idle_gap();
      end
      drain_list_rsps();
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/rrel_pkg.sv
hw/rtl/rrel_ram.sv
hw/rtl/round_robin_entry_list_unit.sv
tb/sv/round_robin_entry_list_unit_tb.sv
